[sv/hkt_pkg.sv]
package hkt_pkg;

    // Request modes; the unused code is served as a lookup
    localparam logic [1:0] MODE_LOOKUP = 2'd0;
    localparam logic [1:0] MODE_INSERT = 2'd1;
    localparam logic [1:0] MODE_REMOVE = 2'd2;
    localparam logic [1:0] MODE_SPARE  = 2'd3;

    // Result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_PRESENT = 2'd1;
    localparam logic [1:0] ST_MISSING = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    // 64-bit hash constants; the offset basis is not the standard FNV-1 value
    localparam logic [63:0] FNV_BASIS = 64'hcbf29ce484222425;
    localparam int          KEY_BYTES = 14;
    localparam int          HASH_W    = 64;
    localparam int          KEY_W     = 112;
    localparam int          MOD_BITS  = 4;   // remainder bits consumed per cycle

    typedef enum logic [1:0] {
        FR_IDLE,
        FR_HASH,
        FR_MOD,
        FR_PUSH
    } t_front_state;

    typedef enum logic [3:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_HEAD,
        BK_WALK,
        BK_SCAN,
        BK_INS1,
        BK_INS2,
        BK_REM1,
        BK_REM2,
        BK_DONE
    } t_back_state;

    // FNV-1 multiply by 0x100000001b3, modulo 2^64, as shifts and adds
    function automatic logic [63:0] fnv_mul(input logic [63:0] h);
        fnv_mul = (h << 40) + (h << 8) + (h << 7) + (h << 5) + (h << 4) + (h << 1) + h;
    endfunction

endpackage

[sv/hkt_ram.sv]
module hkt_ram #(
    parameter int W = 8,
    parameter int D = 16
) (
    input  logic                            i_clk,
    input  logic                            i_we,
    input  logic [$clog2(D > 1 ? D : 2)-1:0] i_waddr,
    input  logic [W-1:0]                    i_wdata,
    input  logic [$clog2(D > 1 ? D : 2)-1:0] i_raddr,
    output logic [W-1:0]                    o_rdata
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[sv/hkt_queue.sv]
module hkt_queue #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic         o_valid,
    output logic [W-1:0] o_data
);

    logic [W-1:0] r_buf [2];
    logic         r_wp;
    logic         r_rp;
    logic [1:0]   r_cnt;
    logic         w_push;
    logic         w_pop;

    assign w_push  = i_push && (r_cnt != 2'd2);
    assign w_pop   = i_pop && (r_cnt != 2'd0);
    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_buf[r_rp];

    // Two-entry queue between hashing and table work
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_buf[r_wp] <= i_data;
        end
    end

endmodule

[sv/hkt_front.sv]
module hkt_front #(
    parameter int BUCKETS = 337
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_hold,
    input  logic                                     i_valid,
    output logic                                     o_stall,
    input  logic [1:0]                               i_mode,
    input  logic [63:0]                              i_key_low,
    input  logic [47:0]                              i_key_high,
    output logic                                     o_push,
    input  logic                                     i_full,
    output logic [1:0]                               o_mode,
    output logic [63:0]                              o_key_low,
    output logic [47:0]                              o_key_high,
    output logic [$clog2(BUCKETS > 1 ? BUCKETS : 2)-1:0] o_bucket
);

    localparam int BW = $clog2(BUCKETS > 1 ? BUCKETS : 2);
    localparam int RW = BW + 1;
    localparam logic [RW-1:0] BMOD = RW'(BUCKETS);
    localparam logic [3:0] HASH_LAST = 4'(hkt_pkg::KEY_BYTES - 1);
    localparam logic [3:0] MOD_LAST  = 4'(hkt_pkg::HASH_W / hkt_pkg::MOD_BITS - 1);

    hkt_pkg::t_front_state r_state, n_state;
    logic [1:0]  r_mode;
    logic [63:0] r_key_lo;
    logic [47:0] r_key_hi;
    logic [63:0] r_h, n_h;
    logic [RW-1:0] r_rem, n_rem;
    logic [3:0]  r_cnt, n_cnt;
    logic [hkt_pkg::KEY_W-1:0] w_key;
    logic [7:0]  w_byte;
    logic        w_accept;

    assign w_accept = i_valid && !o_stall;
    assign w_key    = {r_key_hi, r_key_lo};
    assign w_byte   = w_key[8*r_cnt +: 8];

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            hkt_pkg::FR_IDLE: if (w_accept) n_state = hkt_pkg::FR_HASH;
            hkt_pkg::FR_HASH: if (r_cnt == HASH_LAST) n_state = hkt_pkg::FR_MOD;
            hkt_pkg::FR_MOD:  if (r_cnt == MOD_LAST) n_state = hkt_pkg::FR_PUSH;
            hkt_pkg::FR_PUSH: if (!i_full) n_state = hkt_pkg::FR_IDLE;
            default:          n_state = hkt_pkg::FR_IDLE;
        endcase
    end

    // Hash one byte a cycle, then reduce four bits a cycle
    always_comb begin
        logic [RW-1:0] rem;
        rem   = r_rem;
        n_h   = r_h;
        n_rem = r_rem;
        n_cnt = r_cnt;
        case (r_state)
            hkt_pkg::FR_IDLE: begin
                n_h   = hkt_pkg::FNV_BASIS;
                n_cnt = 4'd0;
            end
            hkt_pkg::FR_HASH: begin
                n_h   = hkt_pkg::fnv_mul(r_h) ^ {56'd0, w_byte};
                n_cnt = (r_cnt == HASH_LAST) ? 4'd0 : r_cnt + 4'd1;
                n_rem = '0;
            end
            hkt_pkg::FR_MOD: begin
                for (int k = 0; k < hkt_pkg::MOD_BITS; k++) begin
                    rem = {rem[RW-2:0], r_h[hkt_pkg::HASH_W-1-k]};
                    if (rem >= BMOD) begin
                        rem = rem - BMOD;
                    end
                end
                n_rem = rem;
                n_h   = r_h << hkt_pkg::MOD_BITS;
                n_cnt = r_cnt + 4'd1;
            end
            default: begin
                n_cnt = r_cnt;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hkt_pkg::FR_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_h   <= n_h;
        r_rem <= n_rem;
        r_cnt <= n_cnt;
        if (w_accept) begin
            r_mode   <= i_mode;
            r_key_lo <= i_key_low;
            r_key_hi <= i_key_high;
        end
    end

    assign o_stall    = (r_state != hkt_pkg::FR_IDLE) || i_hold;
    assign o_push     = (r_state == hkt_pkg::FR_PUSH);
    assign o_mode     = r_mode;
    assign o_key_low  = r_key_lo;
    assign o_key_high = r_key_hi;
    assign o_bucket   = r_rem[BW-1:0];

endmodule

[sv/hkt_back.sv]
module hkt_back #(
    parameter int BUCKETS      = 337,
    parameter int POOL_ENTRIES = 256
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    output logic                                     o_clearing,
    input  logic                                     i_q_valid,
    output logic                                     o_q_pop,
    input  logic [1:0]                               i_mode,
    input  logic [63:0]                              i_key_low,
    input  logic [47:0]                              i_key_high,
    input  logic [$clog2(BUCKETS > 1 ? BUCKETS : 2)-1:0] i_bucket,
    output logic                                     o_valid,
    input  logic                                     i_stall,
    output logic [1:0]                               o_status,
    output logic [7:0]                               o_slot
);

    localparam int BW = $clog2(BUCKETS > 1 ? BUCKETS : 2);
    localparam int PW = $clog2(POOL_ENTRIES > 1 ? POOL_ENTRIES : 2);
    localparam int LW = $clog2(POOL_ENTRIES + 1);
    localparam int LWX = (LW > PW) ? LW : PW;
    localparam int CMAX = (BUCKETS > POOL_ENTRIES) ? BUCKETS : POOL_ENTRIES;
    localparam int CW = $clog2(CMAX + 1);
    localparam logic [LWX-1:0] NIL = LWX'(POOL_ENTRIES);
    localparam logic [CW-1:0] CLR_END = CW'(CMAX);

    hkt_pkg::t_back_state r_state, n_state;
    logic [1:0]     r_mode, n_mode;
    logic [63:0]    r_klo, n_klo;
    logic [47:0]    r_khi, n_khi;
    logic [BW-1:0]  r_bucket, n_bucket;
    logic [LWX-1:0] r_cur, n_cur;
    logic [LWX-1:0] r_before, n_before;
    logic [LWX-1:0] r_steps, n_steps;
    logic [LWX-1:0] r_hnext, n_hnext;
    logic [LWX-1:0] r_hint, n_hint;
    logic [CW-1:0]  r_clr, n_clr;
    logic [1:0]     r_status, n_status;
    logic [LWX-1:0] r_slot, n_slot;
    logic           r_ovalid;
    logic [1:0]     r_ostatus;
    logic [7:0]     r_oslot;

    // memory ports
    logic [BW-1:0]  w_h_raddr, w_h_waddr;
    logic           w_h_we;
    logic [LWX-1:0] w_h_wdata, w_h_rdata;
    logic [PW-1:0]  w_e_raddr;
    logic [PW-1:0]  w_n_waddr, w_k_waddr, w_u_waddr;
    logic           w_n_we, w_k_we, w_u_we;
    logic [LWX-1:0] w_n_wdata, w_n_rdata;
    logic [hkt_pkg::KEY_W-1:0] w_k_rdata;
    logic           w_u_wdata, w_u_rdata;

    // Chain walk decisions
    logic           w_match;
    logic [LWX-1:0] w_step1, w_scan1;
    logic           w_walk_end;
    logic           w_out_load;

    assign w_match    = w_u_rdata && (w_k_rdata == {r_khi, r_klo});
    assign w_step1    = r_steps + LWX'(1);
    assign w_scan1    = r_cur + LWX'(1);
    assign w_walk_end = (w_n_rdata >= NIL) || (w_step1 >= NIL);
    assign w_out_load = !r_ovalid || !i_stall;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            hkt_pkg::BK_CLEAR: if (r_clr == CLR_END) n_state = hkt_pkg::BK_IDLE;
            hkt_pkg::BK_IDLE:  if (i_q_valid) n_state = hkt_pkg::BK_HEAD;
            hkt_pkg::BK_HEAD: begin
                if (w_h_rdata < NIL) begin
                    n_state = hkt_pkg::BK_WALK;
                end else if (r_mode == hkt_pkg::MODE_INSERT && r_hint < NIL) begin
                    n_state = hkt_pkg::BK_SCAN;
                end else begin
                    n_state = hkt_pkg::BK_DONE;
                end
            end
            hkt_pkg::BK_WALK: begin
                if (w_match) begin
                    n_state = (r_mode == hkt_pkg::MODE_REMOVE) ? hkt_pkg::BK_REM1
                                                               : hkt_pkg::BK_DONE;
                end else if (w_walk_end) begin
                    n_state = (r_mode == hkt_pkg::MODE_INSERT && r_hint < NIL)
                              ? hkt_pkg::BK_SCAN : hkt_pkg::BK_DONE;
                end
            end
            hkt_pkg::BK_SCAN: begin
                if (!w_u_rdata) begin
                    n_state = hkt_pkg::BK_INS1;
                end else if (w_scan1 >= NIL) begin
                    n_state = hkt_pkg::BK_DONE;
                end
            end
            hkt_pkg::BK_INS1: n_state = hkt_pkg::BK_INS2;
            hkt_pkg::BK_INS2: n_state = hkt_pkg::BK_DONE;
            hkt_pkg::BK_REM1: n_state = hkt_pkg::BK_REM2;
            hkt_pkg::BK_REM2: n_state = hkt_pkg::BK_DONE;
            hkt_pkg::BK_DONE: if (w_out_load) n_state = hkt_pkg::BK_IDLE;
            default:          n_state = hkt_pkg::BK_CLEAR;
        endcase
    end

    // Datapath and memory control
    always_comb begin
        n_mode   = r_mode;
        n_klo    = r_klo;
        n_khi    = r_khi;
        n_bucket = r_bucket;
        n_cur    = r_cur;
        n_before = r_before;
        n_steps  = r_steps;
        n_hnext  = r_hnext;
        n_hint   = r_hint;
        n_clr    = r_clr;
        n_status = r_status;
        n_slot   = r_slot;
        o_q_pop  = 1'b0;
        w_h_raddr = i_bucket;
        w_h_waddr = r_bucket;
        w_h_we    = 1'b0;
        w_h_wdata = NIL;
        w_e_raddr = r_cur[PW-1:0];
        w_n_waddr = r_cur[PW-1:0];
        w_n_we    = 1'b0;
        w_n_wdata = NIL;
        w_k_waddr = r_cur[PW-1:0];
        w_k_we    = 1'b0;
        w_u_waddr = r_cur[PW-1:0];
        w_u_we    = 1'b0;
        w_u_wdata = 1'b0;
        case (r_state)
            hkt_pkg::BK_CLEAR: begin
                w_h_waddr = r_clr[BW-1:0];
                w_h_we    = (r_clr < CW'(BUCKETS));
                w_u_waddr = r_clr[PW-1:0];
                w_u_we    = (r_clr < CW'(POOL_ENTRIES));
                n_clr     = r_clr + CW'(1);
                n_hint    = '0;
            end
            hkt_pkg::BK_IDLE: begin
                o_q_pop  = i_q_valid;
                n_mode   = i_mode;
                n_klo    = i_key_low;
                n_khi    = i_key_high;
                n_bucket = i_bucket;
                n_before = NIL;
                n_steps  = '0;
                n_status = hkt_pkg::ST_OK;
                n_slot   = '0;
            end
            hkt_pkg::BK_HEAD: begin
                n_cur     = w_h_rdata;
                w_e_raddr = w_h_rdata[PW-1:0];
                if (w_h_rdata >= NIL) begin
                    if (r_mode == hkt_pkg::MODE_INSERT) begin
                        n_cur     = r_hint;
                        w_e_raddr = r_hint[PW-1:0];
                        n_status  = (r_hint < NIL) ? hkt_pkg::ST_OK : hkt_pkg::ST_FULL;
                    end else begin
                        n_status = hkt_pkg::ST_MISSING;
                    end
                end
            end
            hkt_pkg::BK_WALK: begin
                if (w_match) begin
                    n_hnext = w_n_rdata;
                    if (r_mode == hkt_pkg::MODE_INSERT) begin
                        n_status = hkt_pkg::ST_PRESENT;
                    end else begin
                        n_slot = r_cur;
                    end
                end else begin
                    n_before  = r_cur;
                    n_steps   = w_step1;
                    n_cur     = w_n_rdata;
                    w_e_raddr = w_n_rdata[PW-1:0];
                    if (w_walk_end) begin
                        if (r_mode == hkt_pkg::MODE_INSERT) begin
                            n_cur     = r_hint;
                            w_e_raddr = r_hint[PW-1:0];
                            n_status  = (r_hint < NIL) ? hkt_pkg::ST_OK : hkt_pkg::ST_FULL;
                        end else begin
                            n_status = hkt_pkg::ST_MISSING;
                        end
                    end
                end
            end
            hkt_pkg::BK_SCAN: begin
                // lowest free slot at or above the hint
                if (w_u_rdata) begin
                    n_cur     = w_scan1;
                    w_e_raddr = w_scan1[PW-1:0];
                    if (w_scan1 >= NIL) begin
                        n_status = hkt_pkg::ST_FULL;
                        n_hint   = NIL;
                    end
                end
            end
            hkt_pkg::BK_INS1: begin
                w_k_we    = 1'b1;
                w_u_we    = 1'b1;
                w_u_wdata = 1'b1;
                w_n_we    = 1'b1;
                n_hint    = w_scan1;
                n_slot    = r_cur;
            end
            hkt_pkg::BK_INS2: begin
                w_h_wdata = r_cur;
                w_n_wdata = r_cur;
                w_n_waddr = r_before[PW-1:0];
                w_n_we    = (r_before < NIL);
                w_h_we    = (r_before >= NIL);
            end
            hkt_pkg::BK_REM1: begin
                w_u_we = 1'b1;
                w_n_we = 1'b1;
                if (r_cur < r_hint) begin
                    n_hint = r_cur;
                end
            end
            hkt_pkg::BK_REM2: begin
                w_h_wdata = r_hnext;
                w_n_wdata = r_hnext;
                w_n_waddr = r_before[PW-1:0];
                w_n_we    = (r_before < NIL);
                w_h_we    = (r_before >= NIL);
            end
            default: begin
                n_clr = r_clr;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= hkt_pkg::BK_CLEAR;
            r_clr    <= '0;
            r_hint   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_hint  <= n_hint;
            if (r_state == hkt_pkg::BK_DONE && w_out_load) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode   <= n_mode;
        r_klo    <= n_klo;
        r_khi    <= n_khi;
        r_bucket <= n_bucket;
        r_cur    <= n_cur;
        r_before <= n_before;
        r_steps  <= n_steps;
        r_hnext  <= n_hnext;
        r_status <= n_status;
        r_slot   <= n_slot;
        if (r_state == hkt_pkg::BK_DONE && w_out_load) begin
            r_ostatus <= r_status;
            r_oslot   <= (r_status == hkt_pkg::ST_OK) ? 8'(r_slot) : 8'd0;
        end
    end

    // Table storage
    hkt_ram #(.W(LWX), .D(BUCKETS)) u_head (
        .i_clk  (i_clk),
        .i_we   (w_h_we),
        .i_waddr(w_h_waddr),
        .i_wdata(w_h_wdata),
        .i_raddr(w_h_raddr),
        .o_rdata(w_h_rdata)
    );

    hkt_ram #(.W(LWX), .D(POOL_ENTRIES)) u_next (
        .i_clk  (i_clk),
        .i_we   (w_n_we),
        .i_waddr(w_n_waddr),
        .i_wdata(w_n_wdata),
        .i_raddr(w_e_raddr),
        .o_rdata(w_n_rdata)
    );

    hkt_ram #(.W(hkt_pkg::KEY_W), .D(POOL_ENTRIES)) u_key (
        .i_clk  (i_clk),
        .i_we   (w_k_we),
        .i_waddr(w_k_waddr),
        .i_wdata({r_khi, r_klo}),
        .i_raddr(w_e_raddr),
        .o_rdata(w_k_rdata)
    );

    hkt_ram #(.W(1), .D(POOL_ENTRIES)) u_used (
        .i_clk  (i_clk),
        .i_we   (w_u_we),
        .i_waddr(w_u_waddr),
        .i_wdata(w_u_wdata),
        .i_raddr(w_e_raddr),
        .o_rdata(w_u_rdata)
    );

    assign o_clearing = (r_state == hkt_pkg::BK_CLEAR);
    assign o_valid    = r_ovalid;
    assign o_status   = r_ostatus;
    assign o_slot     = r_oslot;

`ifndef SYNTHESIS
    a_hint_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hint <= NIL) else $error("free-slot hint beyond pool");
    a_no_out_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == hkt_pkg::BK_CLEAR) |-> !r_ovalid) else $error("result during clear");
    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == hkt_pkg::BK_WALK) |-> (r_steps < NIL && r_cur < NIL))
        else $error("chain walk out of range");
    a_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> (r_ostatus == hkt_pkg::ST_OK || r_oslot == 8'd0))
        else $error("slot nonzero on failed request");
`endif

endmodule

[sv/hashed_key_table.sv]
// Hashed key table: 14-byte keys in chained hash buckets over a slot pool.
// Input channel (i_valid / o_stall) carries mode, key_low, key_high; an item
// is taken at an edge with i_valid high and o_stall low. Output channel
// (o_valid / i_stall) returns one status and slot per request, in order.
// The front hashes one key byte per cycle and reduces the hash modulo
// BUCKETS four bits per cycle; it takes no new request until it has pushed
// the last one into the queue. A two-entry queue feeds the back, which
// reads the bucket head, walks the chain one entry per cycle through the
// registered-read RAMs, searches the lowest free slot one slot per cycle
// at or above a hint, and makes each insert or remove update in the
// states INS1 then INS2, or REM1 then REM2.
// After reset the back runs a clearing pass over the head and used
// memories; o_stall is high until it ends.
// When i_stall holds off the result, the result register keeps it; the back
// waits with the next result; the front hashes into the queue until it fills.
module hashed_key_table #(
    parameter int BUCKETS      = 337,
    parameter int POOL_ENTRIES = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_mode,
    input  logic [63:0] i_key_low,
    input  logic [47:0] i_key_high,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic [7:0]  o_slot
);

    localparam int BW = $clog2(BUCKETS > 1 ? BUCKETS : 2);
    localparam int QW = 2 + hkt_pkg::KEY_W + BW;

    logic          w_clearing;
    logic          w_push, w_full, w_pop, w_qvalid;
    logic [1:0]    w_f_mode;
    logic [63:0]   w_f_klo;
    logic [47:0]   w_f_khi;
    logic [BW-1:0] w_f_bucket;
    logic [QW-1:0] w_qdata;

    // Hash front
    hkt_front #(.BUCKETS(BUCKETS)) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_hold    (w_clearing),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_mode    (i_mode),
        .i_key_low (i_key_low),
        .i_key_high(i_key_high),
        .o_push    (w_push),
        .i_full    (w_full),
        .o_mode    (w_f_mode),
        .o_key_low (w_f_klo),
        .o_key_high(w_f_khi),
        .o_bucket  (w_f_bucket)
    );

    // Request queue
    hkt_queue #(.W(QW)) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_push),
        .i_data ({w_f_mode, w_f_khi, w_f_klo, w_f_bucket}),
        .o_full (w_full),
        .i_pop  (w_pop),
        .o_valid(w_qvalid),
        .o_data (w_qdata)
    );

    // Table back end
    hkt_back #(.BUCKETS(BUCKETS), .POOL_ENTRIES(POOL_ENTRIES)) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .o_clearing(w_clearing),
        .i_q_valid (w_qvalid),
        .o_q_pop   (w_pop),
        .i_mode    (w_qdata[QW-1 -: 2]),
        .i_key_high(w_qdata[BW+64 +: 48]),
        .i_key_low (w_qdata[BW +: 64]),
        .i_bucket  (w_qdata[BW-1:0]),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_status  (o_status),
        .o_slot    (o_slot)
    );

endmodule
